/* sv/hcwb_pkg.sv */
package hcwb_pkg;

    localparam int unsigned BUFFER_DEPTH_DEFAULT = 32;

    localparam int CHAN_W      = 12;
    localparam int TAC_W       = 2;
    localparam int TIME_W      = 48;
    localparam int ENERGY_W    = 16;
    localparam int TOT_W       = 16;
    localparam int QUAL_W      = 10;
    localparam int EVENT_W     = 32;
    localparam int COUNT_OUT_W = 6;
    localparam int WINDOW_W    = 24;
    localparam int MIN_HITS_W  = 6;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 1;

    localparam logic [WINDOW_W-1:0]   WINDOW_PS_RESET = 24'd20000;
    localparam logic [MIN_HITS_W-1:0] MIN_HITS_RESET  = 6'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_PS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_HITS  = 1'b1;

    localparam logic CMD_HIT   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [TAC_W-1:0]    tac;
        logic [TIME_W-1:0]   time_ps;
        logic [ENERGY_W-1:0] energy;
        logic [TOT_W-1:0]    over_threshold;
        logic [QUAL_W-1:0]   time_quality;
        logic [QUAL_W-1:0]   energy_quality;
    } hit_t;

    localparam int HIT_W = $bits(hit_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT,
        ST_CLOSE
    } state_t;

endpackage

/* sv/hcwb_ram.sv */
module hcwb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/hit_coincidence_window_builder.sv */
// Coincidence window event builder. Takes time-ordered hits (or a flush
// command) on the s_ channel and emits each closed window that holds at
// least min_hits hits as a run of words on the m_ channel, one word per
// stored hit in arrival order, with m_last on the final word. A hit whose
// absolute distance from the window's first hit is below window_ps joins
// the window; the first hit at or beyond it closes the window and opens the
// next. Hits past BUFFER_DEPTH are dropped and flagged in m_overflowed.
// Each input word is captured, then evaluated against the reference time
// and written into the hit RAM. A word that closes a qualifying window is
// held while the window is replayed from the RAM's single read port at one
// word per cycle when the result side does not stall. Configuration must be
// written through cfg_wr_en / cfg_index / cfg_data only while the block is
// idle; the block itself does not enforce this.
module hit_coincidence_window_builder #(
    parameter int BUFFER_DEPTH = hcwb_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [hcwb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hcwb_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [hcwb_pkg::CHAN_W-1:0]       s_channel_id,
    input  logic [hcwb_pkg::TAC_W-1:0]        s_tac_id,
    input  logic [hcwb_pkg::TIME_W-1:0]       s_time_ps,
    input  logic [hcwb_pkg::ENERGY_W-1:0]     s_energy,
    input  logic [hcwb_pkg::TOT_W-1:0]        s_over_threshold,
    input  logic [hcwb_pkg::QUAL_W-1:0]       s_time_quality,
    input  logic [hcwb_pkg::QUAL_W-1:0]       s_energy_quality,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [hcwb_pkg::EVENT_W-1:0]      m_event_number,
    output logic [hcwb_pkg::COUNT_OUT_W-1:0]  m_hit_count,
    output logic                              m_overflowed,
    output logic [hcwb_pkg::CHAN_W-1:0]       m_hit_channel,
    output logic [hcwb_pkg::TAC_W-1:0]        m_hit_tac,
    output logic [hcwb_pkg::TIME_W-1:0]       m_hit_time_ps,
    output logic [hcwb_pkg::ENERGY_W-1:0]     m_hit_energy,
    output logic [hcwb_pkg::TOT_W-1:0]        m_hit_over_threshold,
    output logic [hcwb_pkg::QUAL_W-1:0]       m_hit_time_quality,
    output logic [hcwb_pkg::QUAL_W-1:0]       m_hit_energy_quality,
    output logic                              m_last
);

    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int CMP_W = CNT_W + hcwb_pkg::MIN_HITS_W;

    // Control state
    hcwb_pkg::state_t                 state_reg, state_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic                             dropped_reg, dropped_next;
    logic [hcwb_pkg::EVENT_W-1:0]     event_reg, event_next;
    logic [hcwb_pkg::TIME_W-1:0]      ref_time_reg, ref_time_next;
    logic [hcwb_pkg::WINDOW_W-1:0]    window_reg;
    logic [hcwb_pkg::MIN_HITS_W-1:0]  min_hits_reg;

    // Replay pipeline: read issue, RAM output stage, output register
    logic [CNT_W-1:0]                 issue_reg, issue_next;
    logic                             ram_dv_reg, ram_dv_next;
    logic                             ram_last_reg, ram_last_next;
    logic                             m_valid_reg, m_valid_next;

    // Held input word
    logic                             cmd_reg;
    hcwb_pkg::hit_t                   hit_in_reg;

    // Output word register
    hcwb_pkg::hit_t                   out_hit_reg;
    logic [hcwb_pkg::EVENT_W-1:0]     out_event_reg;
    logic [hcwb_pkg::COUNT_OUT_W-1:0] out_count_reg;
    logic                             out_ovf_reg;
    logic                             out_last_reg;

    // Hit RAM ports
    logic                             ram_wr_en;
    logic [AW-1:0]                    ram_wr_addr;
    logic                             ram_rd_en;
    logic [hcwb_pkg::HIT_W-1:0]       ram_rd_data;
    hcwb_pkg::hit_t                   ram_hit;

    logic                             s_accept;
    logic                             move;
    logic [hcwb_pkg::TIME_W-1:0]      diff_fwd, diff_bwd, diff_abs;
    logic                             in_window;
    logic [CMP_W-1:0]                 count_cmp, min_cmp;
    logic                             qualify;

    assign s_ready  = (state_reg == hcwb_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign ram_hit  = hcwb_pkg::hit_t'(ram_rd_data);

    // Absolute distance from the reference hit against the window
    assign diff_fwd  = hit_in_reg.time_ps - ref_time_reg;
    assign diff_bwd  = ref_time_reg - hit_in_reg.time_ps;
    assign diff_abs  = (hit_in_reg.time_ps >= ref_time_reg) ? diff_fwd : diff_bwd;
    assign in_window = diff_abs < {{(hcwb_pkg::TIME_W - hcwb_pkg::WINDOW_W){1'b0}}, window_reg};

    // An open window is emitted only with at least min_hits hits
    assign count_cmp = {{hcwb_pkg::MIN_HITS_W{1'b0}}, count_reg};
    assign min_cmp   = {{CNT_W{1'b0}}, min_hits_reg};
    assign qualify   = (count_reg != '0) && (count_cmp >= min_cmp);

    // Shift a word from the RAM stage into the output register when it frees up
    assign move = ram_dv_reg && (!m_valid_reg || m_ready);

    hcwb_ram #(
        .WIDTH (hcwb_pkg::HIT_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_hcwb_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (hit_in_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (issue_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        event_next    = event_reg;
        ref_time_next = ref_time_reg;
        issue_next    = issue_reg;
        ram_dv_next   = ram_dv_reg && !move;
        ram_last_next = ram_last_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = '0;
        ram_rd_en     = 1'b0;

        if (move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        unique case (state_reg)
            hcwb_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = hcwb_pkg::ST_EVAL;
                end
            end

            hcwb_pkg::ST_EVAL: begin
                state_next = hcwb_pkg::ST_IDLE;
                if (cmd_reg == hcwb_pkg::CMD_FLUSH) begin
                    // Flush: replay if large enough, close either way
                    if (qualify) begin
                        state_next = hcwb_pkg::ST_EMIT;
                        issue_next = '0;
                    end else begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end
                end else if (count_reg == '0) begin
                    // Open a fresh window on this hit
                    ref_time_next = hit_in_reg.time_ps;
                    ram_wr_en     = 1'b1;
                    count_next    = CNT_W'(1);
                    dropped_next  = 1'b0;
                end else if (in_window) begin
                    // Store, or drop and flag when the buffer is full
                    if (count_reg < CNT_W'(BUFFER_DEPTH)) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_reg[AW-1:0];
                        count_next  = count_reg + 1'b1;
                    end else begin
                        dropped_next = 1'b1;
                    end
                end else if (qualify) begin
                    // Outside the window: replay first, reopen afterwards
                    state_next = hcwb_pkg::ST_EMIT;
                    issue_next = '0;
                end else begin
                    // Discard the short window and reopen on this hit
                    ref_time_next = hit_in_reg.time_ps;
                    ram_wr_en     = 1'b1;
                    count_next    = CNT_W'(1);
                    dropped_next  = 1'b0;
                end
            end

            hcwb_pkg::ST_EMIT: begin
                if ((issue_reg < count_reg) && (!ram_dv_reg || move)) begin
                    ram_rd_en     = 1'b1;
                    issue_next    = issue_reg + 1'b1;
                    ram_dv_next   = 1'b1;
                    ram_last_next = (issue_reg == count_reg - 1'b1);
                end else if ((issue_reg == count_reg) && !ram_dv_reg) begin
                    state_next = hcwb_pkg::ST_CLOSE;
                end
            end

            hcwb_pkg::ST_CLOSE: begin
                // Advance the event number, clear the window, reopen on a hit
                event_next   = event_reg + 1'b1;
                count_next   = '0;
                dropped_next = 1'b0;
                state_next   = hcwb_pkg::ST_IDLE;
                if (cmd_reg == hcwb_pkg::CMD_HIT) begin
                    ref_time_next = hit_in_reg.time_ps;
                    ram_wr_en     = 1'b1;
                    count_next    = CNT_W'(1);
                end
            end

            default: begin
                state_next = hcwb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hcwb_pkg::ST_IDLE;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            event_reg    <= '0;
            ref_time_reg <= '0;
            window_reg   <= hcwb_pkg::WINDOW_PS_RESET;
            min_hits_reg <= hcwb_pkg::MIN_HITS_RESET;
            issue_reg    <= '0;
            ram_dv_reg   <= 1'b0;
            ram_last_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            event_reg    <= event_next;
            ref_time_reg <= ref_time_next;
            issue_reg    <= issue_next;
            ram_dv_reg   <= ram_dv_next;
            ram_last_reg <= ram_last_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    hcwb_pkg::REG_WINDOW_PS: window_reg   <= cfg_data;
                    hcwb_pkg::REG_MIN_HITS:  min_hits_reg <= cfg_data[hcwb_pkg::MIN_HITS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg                   <= s_command;
            hit_in_reg.channel        <= s_channel_id;
            hit_in_reg.tac            <= s_tac_id;
            hit_in_reg.time_ps        <= s_time_ps;
            hit_in_reg.energy         <= s_energy;
            hit_in_reg.over_threshold <= s_over_threshold;
            hit_in_reg.time_quality   <= s_time_quality;
            hit_in_reg.energy_quality <= s_energy_quality;
        end
        if (move) begin
            out_hit_reg   <= ram_hit;
            out_event_reg <= event_reg;
            out_count_reg <= count_cmp[hcwb_pkg::COUNT_OUT_W-1:0];
            out_ovf_reg   <= dropped_reg;
            out_last_reg  <= ram_last_reg;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_event_number       = out_event_reg;
    assign m_hit_count          = out_count_reg;
    assign m_overflowed         = out_ovf_reg;
    assign m_hit_channel        = out_hit_reg.channel;
    assign m_hit_tac            = out_hit_reg.tac;
    assign m_hit_time_ps        = out_hit_reg.time_ps;
    assign m_hit_energy         = out_hit_reg.energy;
    assign m_hit_over_threshold = out_hit_reg.over_threshold;
    assign m_hit_time_quality   = out_hit_reg.time_quality;
    assign m_hit_energy_quality = out_hit_reg.energy_quality;
    assign m_last               = out_last_reg;

endmodule

/* sv/hcwb_checker.sv */
module hcwb_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [hcwb_pkg::EVENT_W-1:0]     m_event_number,
    input logic [hcwb_pkg::TIME_W-1:0]      m_hit_time_ps,
    input logic                             m_last
);

    logic                         in_event_reg;
    logic                         seen_reg;
    logic [hcwb_pkg::EVENT_W-1:0] evt_reg;
    logic                         m_accept;

    assign m_accept = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_event_reg <= 1'b0;
            seen_reg     <= 1'b0;
            evt_reg      <= '0;
        end else if (m_accept) begin
            in_event_reg <= !m_last;
            seen_reg     <= 1'b1;
            evt_reg      <= m_event_number;
        end
    end

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_number) && $stable(m_hit_time_ps)
            && $stable(m_last))
        else $error("result word changed while stalled");

    // Keep one event number across all words of an event
    a_evt_same: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && in_event_reg |-> m_event_number == evt_reg)
        else $error("event number changed inside an event");

    // Advance the event number by one from event to event
    a_evt_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !in_event_reg && seen_reg |-> m_event_number == evt_reg + 1'b1)
        else $error("event number skipped or repeated");

    // Take no new input word while an event is only partly delivered
    a_no_input_mid_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input taken during event replay");

endmodule

bind hit_coincidence_window_builder hcwb_checker u_hcwb_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_event_number (m_event_number),
    .m_hit_time_ps  (m_hit_time_ps),
    .m_last         (m_last)
);

/* tb/sv/window_event_checker.sv */
module window_event_checker #(
    parameter int BUFFER_DEPTH = hcwb_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [hcwb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hcwb_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_command,
    input  logic [hcwb_pkg::CHAN_W-1:0]      s_channel_id,
    input  logic [hcwb_pkg::TAC_W-1:0]       s_tac_id,
    input  logic [hcwb_pkg::TIME_W-1:0]      s_time_ps,
    input  logic [hcwb_pkg::ENERGY_W-1:0]    s_energy,
    input  logic [hcwb_pkg::TOT_W-1:0]       s_over_threshold,
    input  logic [hcwb_pkg::QUAL_W-1:0]      s_time_quality,
    input  logic [hcwb_pkg::QUAL_W-1:0]      s_energy_quality,

    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [hcwb_pkg::EVENT_W-1:0]     m_event_number,
    input  logic [hcwb_pkg::COUNT_OUT_W-1:0] m_hit_count,
    input  logic                             m_overflowed,
    input  logic [hcwb_pkg::CHAN_W-1:0]      m_hit_channel,
    input  logic [hcwb_pkg::TAC_W-1:0]       m_hit_tac,
    input  logic [hcwb_pkg::TIME_W-1:0]      m_hit_time_ps,
    input  logic [hcwb_pkg::ENERGY_W-1:0]    m_hit_energy,
    input  logic [hcwb_pkg::TOT_W-1:0]       m_hit_over_threshold,
    input  logic [hcwb_pkg::QUAL_W-1:0]      m_hit_time_quality,
    input  logic [hcwb_pkg::QUAL_W-1:0]      m_hit_energy_quality,
    input  logic                             m_last,

    output int                               fault_count,
    output int                               outstanding
);

    localparam int TW = hcwb_pkg::TIME_W;

    typedef struct {
        logic [hcwb_pkg::EVENT_W-1:0]     event_number;
        logic [hcwb_pkg::COUNT_OUT_W-1:0] hit_count;
        logic                             overflowed;
        hcwb_pkg::hit_t                   hit;
        logic                             last;
    } event_word_t;

    // Shadow of the block's configuration and window state
    logic [hcwb_pkg::WINDOW_W-1:0]   win_ps;
    logic [hcwb_pkg::MIN_HITS_W-1:0] min_count;
    logic [TW-1:0]                   ref_ps;
    int                              held_count;
    hcwb_pkg::hit_t                  held_hits [BUFFER_DEPTH];
    logic                            dropped;
    logic [hcwb_pkg::EVENT_W-1:0]    event_no;

    event_word_t event_words [$];
    int          faults;
    int          queued;

    assign fault_count = faults;
    assign outstanding = queued;

    function automatic void hold_hit(input hcwb_pkg::hit_t h);
        if (held_count >= BUFFER_DEPTH) begin
            dropped = 1'b1;
        end else begin
            held_hits[held_count] = h;
            held_count++;
        end
    endfunction

    // Replay the window as event words if it holds enough hits, then clear it
    function automatic void close_window();
        event_word_t w;
        if (held_count > 0 && held_count >= int'(min_count)) begin
            for (int i = 0; i < held_count; i++) begin
                w.event_number = event_no;
                w.hit_count    = hcwb_pkg::COUNT_OUT_W'(held_count);
                w.overflowed   = dropped;
                w.hit          = held_hits[i];
                w.last         = (i == held_count - 1);
                event_words.insert(event_words.size(), w);
            end
            event_no++;
        end
        held_count = 0;
        dropped    = 1'b0;
    endfunction

    function automatic void open_window(input hcwb_pkg::hit_t h);
        ref_ps     = h.time_ps;
        held_count = 0;
        dropped    = 1'b0;
        hold_hit(h);
    endfunction

    function automatic int differs(input string name, input logic [TW-1:0] want,
                                   input logic [TW-1:0] got);
        if (want !== got) begin
            $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : predict_and_compare
        hcwb_pkg::hit_t h;
        event_word_t    want;
        logic [TW-1:0]  dist_ps;
        int             bad;
        if (!aresetn) begin
            win_ps     = hcwb_pkg::WINDOW_PS_RESET;
            min_count  = hcwb_pkg::MIN_HITS_RESET;
            ref_ps     = '0;
            held_count = 0;
            dropped    = 1'b0;
            event_no   = '0;
            faults     = 0;
            event_words.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    hcwb_pkg::REG_WINDOW_PS: win_ps = cfg_data[hcwb_pkg::WINDOW_W-1:0];
                    hcwb_pkg::REG_MIN_HITS:  min_count = cfg_data[hcwb_pkg::MIN_HITS_W-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                h.channel        = s_channel_id;
                h.tac            = s_tac_id;
                h.time_ps        = s_time_ps;
                h.energy         = s_energy;
                h.over_threshold = s_over_threshold;
                h.time_quality   = s_time_quality;
                h.energy_quality = s_energy_quality;
                if (s_command == hcwb_pkg::CMD_FLUSH) begin
                    close_window();
                end else if (held_count == 0) begin
                    open_window(h);
                end else begin
                    dist_ps = (h.time_ps >= ref_ps) ? h.time_ps - ref_ps : ref_ps - h.time_ps;
                    if (dist_ps < TW'(win_ps)) begin
                        hold_hit(h);
                    end else begin
                        close_window();
                        open_window(h);
                    end
                end
            end

            if (m_valid && m_ready) begin
                if (event_words.size() == 0) begin
                    $display("[%0t] unexpected word: expected none, actual event %0h channel %0h",
                             $time, m_event_number, m_hit_channel);
                    faults++;
                end else begin
                    want = event_words.pop_front();
                    bad  = 0;
                    bad += differs("event_number", TW'(want.event_number),
                                   TW'(m_event_number));
                    bad += differs("hit_count", TW'(want.hit_count), TW'(m_hit_count));
                    bad += differs("overflowed", TW'(want.overflowed), TW'(m_overflowed));
                    bad += differs("hit_channel", TW'(want.hit.channel), TW'(m_hit_channel));
                    bad += differs("hit_tac", TW'(want.hit.tac), TW'(m_hit_tac));
                    bad += differs("hit_time_ps", want.hit.time_ps, m_hit_time_ps);
                    bad += differs("hit_energy", TW'(want.hit.energy), TW'(m_hit_energy));
                    bad += differs("hit_over_threshold", TW'(want.hit.over_threshold),
                                   TW'(m_hit_over_threshold));
                    bad += differs("hit_time_quality", TW'(want.hit.time_quality),
                                   TW'(m_hit_time_quality));
                    bad += differs("hit_energy_quality", TW'(want.hit.energy_quality),
                                   TW'(m_hit_energy_quality));
                    bad += differs("last", TW'(want.last), TW'(m_last));
                    faults += bad;
                end
            end
        end
        queued <= event_words.size();
    end

endmodule

/* tb/sv/testbench.sv */
module testbench;

    localparam int DEPTH           = hcwb_pkg::BUFFER_DEPTH_DEFAULT;
    localparam int TW              = hcwb_pkg::TIME_W;
    localparam int PHASES          = 8;
    // Phase whose start is met by a long receiver hold-off and which pauses half way
    localparam int HOLD_PHASE      = 5;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_CYCLES    = 12;
    localparam int DRAIN_CYCLES    = 60;
    localparam int RUN_LIMIT       = 5_000_000;
    localparam logic [TW-1:0] TIME_TOP    = {TW{1'b1}};
    localparam logic [TW-1:0] WRAP_MARGIN = 48'd33554432;

    logic                             aclk    = 1'b0;
    logic                             aresetn = 1'b0;

    logic                             cfg_wr_en = 1'b0;
    logic [hcwb_pkg::CFG_INDEX_W-1:0] cfg_index = hcwb_pkg::REG_WINDOW_PS;
    logic [hcwb_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    logic                             s_valid          = 1'b0;
    logic                             s_ready;
    logic                             s_command        = hcwb_pkg::CMD_HIT;
    logic [hcwb_pkg::CHAN_W-1:0]      s_channel_id     = '0;
    logic [hcwb_pkg::TAC_W-1:0]       s_tac_id         = '0;
    logic [TW-1:0]                    s_time_ps        = '0;
    logic [hcwb_pkg::ENERGY_W-1:0]    s_energy         = '0;
    logic [hcwb_pkg::TOT_W-1:0]       s_over_threshold = '0;
    logic [hcwb_pkg::QUAL_W-1:0]      s_time_quality   = '0;
    logic [hcwb_pkg::QUAL_W-1:0]      s_energy_quality = '0;

    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [hcwb_pkg::EVENT_W-1:0]     m_event_number;
    logic [hcwb_pkg::COUNT_OUT_W-1:0] m_hit_count;
    logic                             m_overflowed;
    logic [hcwb_pkg::CHAN_W-1:0]      m_hit_channel;
    logic [hcwb_pkg::TAC_W-1:0]       m_hit_tac;
    logic [TW-1:0]                    m_hit_time_ps;
    logic [hcwb_pkg::ENERGY_W-1:0]    m_hit_energy;
    logic [hcwb_pkg::TOT_W-1:0]       m_hit_over_threshold;
    logic [hcwb_pkg::QUAL_W-1:0]      m_hit_time_quality;
    logic [hcwb_pkg::QUAL_W-1:0]      m_hit_energy_quality;
    logic                             m_last;

    int fault_count;
    int outstanding;

    // Set by the stimulus to ask the result side for one long hold-off
    bit          hold_off_req = 1'b0;
    // Offer words back to back while set
    bit          steady_send  = 1'b0;
    int          sent         = 0;
    int unsigned cur_window   = 20000;

    // Configuration per phase: window, minimum hits, word budget, and a forced
    // first window size (zero for none) to push the buffer past full
    logic [hcwb_pkg::WINDOW_W-1:0]   phase_window [PHASES] = '{24'd20000, 24'd1, 24'd0,
                                                               24'hFFFFFF, 24'hFFFFFF, 24'd700,
                                                               24'd5000, 24'hFFFFFF};
    logic [hcwb_pkg::MIN_HITS_W-1:0] phase_min    [PHASES] = '{6'd2, 6'd1, 6'd0, 6'd32,
                                                               6'd63, 6'd1, 6'd3, 6'd1};
    int                              phase_words  [PHASES] = '{40, 35, 35, 70, 20, 60, 50, 50};
    int                              phase_first  [PHASES] = '{0, 0, 0, 33, 0, 0, 0, 35};

    always #5 aclk = ~aclk;

    hit_coincidence_window_builder #(
        .BUFFER_DEPTH(DEPTH)
    ) DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_command           (s_command),
        .s_channel_id        (s_channel_id),
        .s_tac_id            (s_tac_id),
        .s_time_ps           (s_time_ps),
        .s_energy            (s_energy),
        .s_over_threshold    (s_over_threshold),
        .s_time_quality      (s_time_quality),
        .s_energy_quality    (s_energy_quality),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_event_number      (m_event_number),
        .m_hit_count         (m_hit_count),
        .m_overflowed        (m_overflowed),
        .m_hit_channel       (m_hit_channel),
        .m_hit_tac           (m_hit_tac),
        .m_hit_time_ps       (m_hit_time_ps),
        .m_hit_energy        (m_hit_energy),
        .m_hit_over_threshold(m_hit_over_threshold),
        .m_hit_time_quality  (m_hit_time_quality),
        .m_hit_energy_quality(m_hit_energy_quality),
        .m_last              (m_last)
    );

    window_event_checker #(
        .BUFFER_DEPTH(DEPTH)
    ) EVENT_CHECK (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_command           (s_command),
        .s_channel_id        (s_channel_id),
        .s_tac_id            (s_tac_id),
        .s_time_ps           (s_time_ps),
        .s_energy            (s_energy),
        .s_over_threshold    (s_over_threshold),
        .s_time_quality      (s_time_quality),
        .s_energy_quality    (s_energy_quality),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_event_number      (m_event_number),
        .m_hit_count         (m_hit_count),
        .m_overflowed        (m_overflowed),
        .m_hit_channel       (m_hit_channel),
        .m_hit_tac           (m_hit_tac),
        .m_hit_time_ps       (m_hit_time_ps),
        .m_hit_energy        (m_hit_energy),
        .m_hit_over_threshold(m_hit_over_threshold),
        .m_hit_time_quality  (m_hit_time_quality),
        .m_hit_energy_quality(m_hit_energy_quality),
        .m_last              (m_last),
        .fault_count         (fault_count),
        .outstanding         (outstanding)
    );

    // Mostly short gaps, now and then a long one; none at all in a steady stretch
    function automatic int pick_gap();
        int r;
        if (steady_send) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TW-1:0] random_stamp();
        return TW'({$urandom, $urandom});
    endfunction

    function automatic hcwb_pkg::hit_t random_hit(input logic [TW-1:0] stamp);
        hcwb_pkg::hit_t h;
        h.channel        = hcwb_pkg::CHAN_W'($urandom);
        h.tac            = hcwb_pkg::TAC_W'($urandom);
        h.time_ps        = stamp;
        h.energy         = hcwb_pkg::ENERGY_W'($urandom);
        h.over_threshold = hcwb_pkg::TOT_W'($urandom);
        h.time_quality   = hcwb_pkg::QUAL_W'($urandom);
        h.energy_quality = hcwb_pkg::QUAL_W'($urandom);
        return h;
    endfunction

    // Offer one word and hold it until the block takes it. Valid is only
    // lowered ahead of a gap, so a back-to-back word never sees valid drop
    // and rise within the same step.
    task automatic send_word(input logic cmd, input hcwb_pkg::hit_t h);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= cmd;
        s_channel_id     <= h.channel;
        s_tac_id         <= h.tac;
        s_time_ps        <= h.time_ps;
        s_energy         <= h.energy;
        s_over_threshold <= h.over_threshold;
        s_time_quality   <= h.time_quality;
        s_energy_quality <= h.energy_quality;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_hit(input logic [TW-1:0] stamp);
        send_word(hcwb_pkg::CMD_HIT, random_hit(stamp));
    endtask

    // Flush payload is ignored by the block; fill it with noise all the same
    task automatic send_flush();
        send_word(hcwb_pkg::CMD_FLUSH, random_hit(random_stamp()));
    endtask

    // Drop valid, wait for every expected word, then give the block time to
    // finish any word that closes nothing
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_config(input logic [hcwb_pkg::WINDOW_W-1:0] window,
                                input logic [hcwb_pkg::MIN_HITS_W-1:0] min_hits);
        cfg_wr_en <= 1'b1;
        cfg_index <= hcwb_pkg::REG_WINDOW_PS;
        cfg_data  <= hcwb_pkg::CFG_DATA_W'(window);
        @(posedge aclk);
        cfg_index <= hcwb_pkg::REG_MIN_HITS;
        cfg_data  <= hcwb_pkg::CFG_DATA_W'(min_hits);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_window = 32'(window);
    endtask

    // Mostly small windows; a few run past the buffer depth where the window is wide
    function automatic int pick_size(input bit allow_overflow);
        int r;
        r = $urandom_range(0, 99);
        if (allow_overflow && r < 6) return $urandom_range(DEPTH + 1, DEPTH + 3);
        if (r < 70) return $urandom_range(1, 4);
        return $urandom_range(5, 12);
    endfunction

    // One well-formed window: n hits, all inside the current window of a random
    // base time, mostly climbing and now and then stepping back. The next
    // window's first hit or a trailing flush closes it.
    task automatic run_window(input int n);
        logic [TW-1:0] base;
        int unsigned   span;
        int unsigned   off;
        base = random_stamp();
        // keep the whole window clear of the wrap of the time field
        if (base > TIME_TOP - WRAP_MARGIN) base = base - WRAP_MARGIN;
        span = (cur_window == 0) ? 0 : cur_window - 1;
        off  = 0;
        steady_send = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                if ($urandom_range(0, 7) == 0) off = $urandom_range(0, span);
                else off = off + $urandom_range(0, (span - off) / 3);
            end
            send_hit(base + off);
        end
        if ($urandom_range(0, 2) == 0) send_flush();
    endtask

    // Result side: ready in stretches, stalls of random length between them,
    // and one long hold-off on request
    initial begin : result_sink
        int stall;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge aclk);
                else repeat ($urandom_range(1, 8)) @(posedge aclk);
                stall = $urandom_range(0, 99);
                if (stall < 50) stall = 0;
                else if (stall < 85) stall = $urandom_range(1, 3);
                else if (stall < 95) stall = $urandom_range(4, 8);
                else stall = $urandom_range(15, 40);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    initial begin : watchdog
        #RUN_LIMIT;
        $display("testbench: errors");
        $finish;
    end

    initial begin : stimulus
        hcwb_pkg::hit_t h;
        int             phase_start;
        int             r;
        bit             paused;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset configuration: window 20000 ps, two hits minimum.
        // Flush with nothing open: no words.
        send_flush();
        // Lowest field values open a window at time zero
        h = '0;
        send_word(hcwb_pkg::CMD_HIT, h);
        // Highest field values, one picosecond short of the window edge: joins
        h = '1;
        h.time_ps = 48'd19999;
        send_word(hcwb_pkg::CMD_HIT, h);
        // Exactly on the edge: closes the two-hit window and opens another
        send_hit(48'd20000);
        // Flush a window holding one hit: too small, dropped silently
        send_flush();
        // Top of the time range, then time running backwards inside the window
        send_hit(TIME_TOP);
        send_hit(TIME_TOP - 48'd19999);
        // Backwards by exactly the window: closes it
        send_hit(TIME_TOP - 48'd20000);
        // Same time as the reference: joins
        send_hit(TIME_TOP - 48'd20000);
        // Flush an open window that qualifies, then flush again with nothing open
        send_flush();
        send_flush();
        settle();

        // Random part, phase by phase
        for (int p = 0; p < PHASES; p++) begin
            apply_config(phase_window[p], phase_min[p]);
            phase_start = sent;
            paused      = 1'b0;
            // the receiver holds off while the sender keeps offering, so the block backs up
            if (p == HOLD_PHASE) hold_off_req = 1'b1;
            if (phase_first[p] > 0) run_window(phase_first[p]);
            while (sent - phase_start < phase_words[p]) begin
                if (p == HOLD_PHASE && !paused && sent - phase_start >= phase_words[p] / 2) begin
                    // hold the sender until every expected word has come
                    settle();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    steady_send = 1'b0;
                    send_flush();
                end else if (r < 14) begin
                    steady_send = 1'b0;
                    send_hit(random_stamp());
                end else begin
                    run_window(pick_size(cur_window >= 5000));
                end
            end
            steady_send = 1'b0;
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0 && outstanding == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
